/* rtl/sdtq_pkg.sv */
//------------------------------------------------------------------------------
// sdtq_pkg
// Shared types, codes and sizes of the sorted deadline timer queue.
//------------------------------------------------------------------------------
package sdtq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS = 8;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_STEP_BITS = 7;

	localparam logic [1:0] KIND_ARM = 2'd0;
	localparam logic [1:0] KIND_REARM = 2'd1;
	localparam logic [1:0] KIND_WITHDRAW = 2'd2;
	localparam logic [1:0] KIND_DRAIN = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_DUPLICATE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] timer_id;
		logic [63:0] deadline;
		logic [63:0] interval;
		logic absolute;
		logic [63:0] now;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic head_valid;
		logic [7:0] head_id;
		logic [63:0] head_deadline;
		logic [4:0] entry_count;
	} out_beat_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic clr;
		logic [ID_BITS-1:0] id;
		logic [63:0] when;
	} cell_cmd_t;

	typedef struct packed {
		logic occ;
		logic le;
		logic hit;
		logic hit_seen;
		logic [ID_BITS-1:0] id;
		logic [63:0] when;
	} cell_stat_t;

endpackage

/* rtl/sdtq_div.sv */
//------------------------------------------------------------------------------
// sdtq_div
// Restoring divider of 64-bit unsigned values, one quotient bit a cycle.
//------------------------------------------------------------------------------
module sdtq_div import sdtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	input logic [63:0] divisor,
	output logic busy,
	output logic [63:0] remainder
);

	logic [DIV_STEP_BITS-1:0] step_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy <= 1'b0;
		end else if (start) begin
			step_q <= '0;
			busy <= 1'b1;
		end else if (busy) begin
			step_q <= step_q + 1'b1;
			if (step_q == DIV_STEP_BITS'(63)) begin
				busy <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign remainder = rem_q;

endmodule

/* rtl/sdtq_cell.sv */
//------------------------------------------------------------------------------
// sdtq_cell
// One slot of the sorted row; it shifts in from either neighbor on insert or
// removal.
//------------------------------------------------------------------------------
module sdtq_cell import sdtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cell_cmd_t cmd,
	input cell_stat_t prev,
	input cell_stat_t next,
	output cell_stat_t stat
);

	logic occ_q;
	logic [ID_BITS-1:0] id_q;
	logic [63:0] when_q;
	logic take_new;
	logic take_prev;
	logic take_next;

	always_comb begin
		stat.occ = occ_q;
		stat.id = id_q;
		stat.when = when_q;
		stat.le = occ_q && (when_q <= cmd.when);
		stat.hit = occ_q && (id_q == cmd.id);
		stat.hit_seen = stat.hit || prev.hit_seen;
		take_new = cmd.ins && !stat.le && prev.le;
		take_prev = cmd.ins && !stat.le && prev.occ && !prev.le;
		take_next = cmd.rem && stat.hit_seen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.clr) begin
			occ_q <= 1'b0;
		end else if (take_new || take_prev) begin
			occ_q <= 1'b1;
		end else if (take_next) begin
			occ_q <= next.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (take_prev) begin
			id_q <= prev.id;
			when_q <= prev.when;
		end else if (take_new) begin
			id_q <= cmd.id;
			when_q <= cmd.when;
		end else if (take_next) begin
			id_q <= next.id;
			when_q <= next.when;
		end
	end

endmodule

/* rtl/sorted_deadline_timer_queue_unit.sv */
//------------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit
// An accepted beat passes S_IDLE, S_EXEC and S_OUT; a rearm that needs catch-up
// also passes S_DIV, waiting on the one-bit-a-cycle 64-bit divider, and S_SUM.
// Only one beat is in flight; the next is accepted in the cycle after the
// result leaves.
// Reset empties the queue; slot contents are not cleared.
//------------------------------------------------------------------------------
module sorted_deadline_timer_queue_unit import sdtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_beat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_beat_t out_data
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV = 5'b00010,
		S_SUM = 5'b00100,
		S_EXEC = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	state_t state_q;
	in_beat_t req_q;
	logic [63:0] when_q;
	logic [63:0] rmd_q;
	logic [63:0] base;
	logic [64:0] fin;
	logic [64:0] first;
	logic [64:0] rel_sum;
	logic div_start;
	logic div_busy;
	logic [63:0] div_rmd;
	logic [CNT_BITS-1:0] count_q;
	logic [1:0] status;
	logic dup;
	logic found;
	cell_cmd_t cmd;
	cell_stat_t stat [QUEUE_DEPTH];
	cell_stat_t prev_s [QUEUE_DEPTH];
	cell_stat_t next_s [QUEUE_DEPTH];

	assign first = {1'b0, in_data.deadline} + {1'b0, in_data.interval};
	assign rel_sum = {1'b0, in_data.now} + {1'b0, in_data.deadline};
	assign div_start = (state_q == S_IDLE) && in_valid && in_data.kind == KIND_REARM
		&& in_data.interval != 64'd0 && !first[64] && first[63:0] <= in_data.now;

	sdtq_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(in_data.now - in_data.deadline), .divisor(in_data.interval),
		.busy(div_busy), .remainder(div_rmd)
	);

	// The last whole period before now ends at now minus the remainder.
	assign base = req_q.now - rmd_q;
	assign fin = {1'b0, base} + {1'b0, req_q.interval};

	always_comb begin
		dup = 1'b0;
		found = 1'b0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			dup = dup | stat[k].hit;
		end
		found = dup;
		if (req_q.kind == KIND_WITHDRAW) begin
			status = found ? ST_OK : ST_NOT_FOUND;
		end else if (req_q.kind == KIND_DRAIN) begin
			status = ST_OK;
		end else if (dup) begin
			status = ST_DUPLICATE;
		end else if (count_q == CNT_BITS'(QUEUE_DEPTH)) begin
			status = ST_FULL;
		end else begin
			status = ST_OK;
		end
		cmd.id = req_q.timer_id[ID_BITS-1:0];
		cmd.when = when_q;
		cmd.ins = (state_q == S_EXEC) && req_q.kind[1] == 1'b0 && status == ST_OK;
		cmd.rem = (state_q == S_EXEC) && req_q.kind == KIND_WITHDRAW && found;
		cmd.clr = (state_q == S_EXEC) && req_q.kind == KIND_DRAIN;
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign prev_s[g] = '{occ: 1'b1, le: 1'b1, hit: 1'b0, hit_seen: 1'b0,
				id: '0, when: '0};
		end else begin : g_mid
			assign prev_s[g] = stat[g-1];
		end
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign next_s[g] = '0;
		end else begin : g_inner
			assign next_s[g] = stat[g+1];
		end
		sdtq_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.prev(prev_s[g]), .next(next_s[g]), .stat(stat[g])
		);
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= div_start ? S_DIV : S_EXEC;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.clr) begin
						count_q <= '0;
					end else if (cmd.ins) begin
						count_q <= count_q + 1'b1;
					end else if (cmd.rem) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
			if (in_data.kind == KIND_ARM) begin
				when_q <= in_data.absolute ? in_data.deadline
					: (rel_sum[64] ? '1 : rel_sum[63:0]);
			end else begin
				when_q <= (in_data.interval == 64'd0) ? in_data.deadline
					: (first[64] ? '1 : first[63:0]);
			end
		end
		if (state_q == S_DIV && !div_busy) begin
			rmd_q <= div_rmd;
		end
		if (state_q == S_SUM) begin
			when_q <= fin[64] ? '1 : fin[63:0];
		end
		if (state_q == S_EXEC) begin
			out_data.status <= status;
		end
		if (state_q == S_OUT && !out_valid) begin
			out_data.head_valid <= stat[0].occ;
			out_data.head_id <= stat[0].occ ? 8'(stat[0].id) : 8'd0;
			out_data.head_deadline <= stat[0].occ ? stat[0].when : 64'd0;
			out_data.entry_count <= 5'(count_q);
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(QUEUE_DEPTH)) else $error("count overflow");
	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> count_q == '0) else $error("drain left entries");

endmodule
